// ===== rtl/bwf_pkg.sv =====
package bwf_pkg;

  // field widths
  localparam int unsigned OffsetBits = 16;
  localparam int unsigned SizeBits   = 17;
  localparam int unsigned HdrBits    = 7;
  localparam int unsigned FragBits   = 7;
  localparam int unsigned TotalBits  = 18;
  localparam int unsigned EntryBits  = OffsetBits + SizeBits;

  typedef logic [1:0] kind_t;
  typedef logic [1:0] status_t;
  typedef logic [1:0] cfg_idx_t;

  // request kinds
  localparam kind_t KindAlloc = 2'd0;
  localparam kind_t KindFree  = 2'd1;
  localparam kind_t KindCount = 2'd2;

  // result codes
  localparam status_t StatOk       = 2'd0;
  localparam status_t StatSize     = 2'd1;
  localparam status_t StatNoSpace  = 2'd2;
  localparam status_t StatNotFound = 2'd3;

  // configuration register indexes
  localparam cfg_idx_t CfgPolicy = 2'd0;
  localparam cfg_idx_t CfgPool   = 2'd1;
  localparam cfg_idx_t CfgHeader = 2'd2;

  localparam logic [SizeBits-1:0] PoolLimit = SizeBits'(1) << OffsetBits;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_PUT
  } state_e;

endpackage

// ===== rtl/bwf_ram.sv =====
module bwf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/best_worst_fit_allocator_top.sv =====
// channel   direction  handshake                  payload
// request   in         start, busy                kind_i, req_size_i, req_offset_i
// result    out        result_valid_o (1 cycle)   status_o, payload_offset_o, fragment_count_o
// config    in         cfg_valid_i, cfg_ready_o   cfg_index_i, cfg_data_i
//
// a request walks the block table one entry a cycle through the table memory
// read port; an allocate then moves entries up to open a slot for the insert,
// a free moves them down over the freed entry. requests rejected up front,
// and any request on an empty table, skip the walk.
// busy stays high until the result strobe; reset clears the block count,
// the table itself holds garbage until written. results cannot be stalled.
module best_worst_fit_allocator_top #(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  bwf_pkg::kind_t                kind_i,
  input  logic [bwf_pkg::SizeBits-1:0]  req_size_i,
  input  logic [bwf_pkg::OffsetBits-1:0] req_offset_i,
  output logic                          result_valid_o,
  output bwf_pkg::status_t              status_o,
  output logic [bwf_pkg::OffsetBits-1:0] payload_offset_o,
  output logic [bwf_pkg::FragBits-1:0]  fragment_count_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  bwf_pkg::cfg_idx_t             cfg_index_i,
  input  logic [bwf_pkg::SizeBits-1:0]  cfg_data_i
);

  import bwf_pkg::*;

  localparam int unsigned AW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned FCW = $clog2(MAX_BLOCKS + 2);
  localparam int unsigned FW  = (FCW > FragBits) ? FCW : FragBits;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_BLOCKS);

  // configuration
  logic                 policy_q;
  logic [SizeBits-1:0]  pool_q;
  logic [HdrBits-1:0]   hdr_q;

  // control state
  state_e               state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        iss_q, iss_d;
  logic [CW-1:0]        sp_q, sp_d;
  logic                 pend_q, pend_d;
  logic [AW-1:0]        pidx_q, pidx_d;
  logic                 up_q, up_d;
  logic                 found_q, found_d;
  logic [FW-1:0]        frag_q, frag_d;
  logic                 done_q;

  // request and working registers
  kind_t                kind_q, kind_d;
  logic [TotalBits-1:0] total_q, total_d;
  logic [OffsetBits-1:0] off_q, off_d;
  logic [SizeBits-1:0]  pend_end_q, pend_end_d;
  logic [SizeBits-1:0]  base_q, base_d;
  logic [SizeBits-1:0]  psize_q, psize_d;
  logic [CW-1:0]        pick_q, pick_d;
  status_t              stat_q, stat_d;
  logic [OffsetBits-1:0] pay_q, pay_d;
  logic [FW-1:0]        frag_out_q, frag_out_d;
  logic                 fin;

  // table memory
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [EntryBits-1:0] wdata, rdata;

  // datapath helpers
  logic [SizeBits-1:0]  pb, bound, hole, rd_end, rd_len;
  logic [OffsetBits-1:0] rd_start;
  logic [SizeBits-1:0]  rd_payload;
  logic                 final_h, evalh, fits, better, upd;
  logic [CW-1:0]        hidx, sp_dec;
  logic [TotalBits-1:0] req_total;

  bwf_ram #(
    .WIDTH(EntryBits),
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != ST_IDLE);

  // pool size saturated to the offset range
  assign pb         = (pool_q > PoolLimit) ? PoolLimit : pool_q;
  assign rd_start   = rdata[EntryBits-1:SizeBits];
  assign rd_len     = rdata[SizeBits-1:0];
  assign rd_end     = {1'b0, rd_start} + rd_len;
  assign rd_payload = {1'b0, rd_start} + SizeBits'(hdr_q);
  assign req_total  = {1'b0, req_size_i} + TotalBits'(hdr_q);
  assign sp_dec     = sp_q - CW'(1);

  // shared hole unit: gap from the previous block end to the next bound
  assign final_h = !pend_q && (iss_q == cnt_q);
  assign evalh   = pend_q || final_h;
  assign bound   = pend_q ? {1'b0, rd_start} : pb;
  assign hole    = (bound > pend_end_q) ? (bound - pend_end_q) : '0;
  assign hidx    = pend_q ? CW'(pidx_q) : cnt_q;
  assign fits    = ({1'b0, hole} >= total_q);
  assign better  = !found_q || (policy_q ? (hole > psize_q) : (hole < psize_q));
  assign upd     = evalh && fits && better;

  // sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    iss_d      = iss_q;
    sp_d       = sp_q;
    pend_d     = 1'b0;
    pidx_d     = pidx_q;
    up_d       = up_q;
    found_d    = found_q;
    frag_d     = frag_q;
    kind_d     = kind_q;
    total_d    = total_q;
    off_d      = off_q;
    pend_end_d = pend_end_q;
    base_d     = base_q;
    psize_d    = psize_q;
    pick_d     = pick_q;
    stat_d     = stat_q;
    pay_d      = pay_q;
    frag_out_d = frag_out_q;
    fin        = 1'b0;
    we         = 1'b0;
    waddr      = pidx_q;
    wdata      = rdata;
    raddr      = iss_q[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          kind_d     = kind_i;
          total_d    = req_total;
          off_d      = req_offset_i;
          pend_end_d = '0;
          iss_d      = '0;
          found_d    = 1'b0;
          frag_d     = '0;
          pay_d      = '0;
          frag_out_d = '0;
          stat_d     = StatOk;
          case (kind_i)
            KindAlloc: begin
              if (req_size_i == '0 || req_total > {1'b0, pb}) begin
                stat_d = StatSize;
                fin    = 1'b1;
              end else if (cnt_q >= MaxCnt) begin
                stat_d = StatNoSpace;
                fin    = 1'b1;
              end else if (cnt_q == '0) begin
                pick_d  = '0;
                base_d  = '0;
                state_d = ST_PUT;
              end else begin
                state_d = ST_SCAN;
              end
            end
            KindFree: begin
              if (cnt_q == '0) begin
                stat_d = StatNotFound;
                fin    = 1'b1;
              end else begin
                state_d = ST_SCAN;
              end
            end
            KindCount: begin
              if (cnt_q == '0) begin
                frag_out_d = ({1'b0, pb} < req_total) ? FW'(1) : '0;
                fin        = 1'b1;
              end else begin
                state_d = ST_SCAN;
              end
            end
            default: begin
              stat_d = StatSize;
              fin    = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // issue the next table read
        if (iss_q < cnt_q) begin
          raddr  = iss_q[AW-1:0];
          iss_d  = iss_q + CW'(1);
          pend_d = 1'b1;
          pidx_d = iss_q[AW-1:0];
        end
        if (kind_q == KindFree) begin
          if (pend_q && rd_payload == {1'b0, off_q}) begin
            pick_d  = CW'(pidx_q);
            sp_d    = CW'(pidx_q) + CW'(1);
            pend_d  = 1'b0;
            up_d    = 1'b0;
            state_d = ST_SHIFT;
          end else if (final_h) begin
            stat_d = StatNotFound;
            fin    = 1'b1;
          end
        end else if (evalh) begin
          if (pend_q) begin
            pend_end_d = rd_end;
          end
          if (kind_q == KindAlloc) begin
            if (upd) begin
              found_d = 1'b1;
              pick_d  = hidx;
              base_d  = pend_end_q;
              psize_d = hole;
            end
            if (final_h) begin
              if (!found_d) begin
                stat_d = StatNoSpace;
                fin    = 1'b1;
              end else if (pick_d == cnt_q) begin
                state_d = ST_PUT;
              end else begin
                sp_d    = cnt_q;
                up_d    = 1'b1;
                state_d = ST_SHIFT;
              end
            end
          end else begin
            if (hole != '0 && {1'b0, hole} < total_q) begin
              frag_d = frag_q + FW'(1);
            end
            if (final_h) begin
              frag_out_d = frag_d;
              fin        = 1'b1;
            end
          end
        end
      end

      ST_SHIFT: begin
        // write back the entry read last cycle one place over
        if (pend_q) begin
          we    = 1'b1;
          waddr = up_q ? (pidx_q + AW'(1)) : (pidx_q - AW'(1));
        end
        if (up_q && sp_q > pick_q) begin
          raddr  = sp_dec[AW-1:0];
          sp_d   = sp_dec;
          pend_d = 1'b1;
          pidx_d = sp_dec[AW-1:0];
        end else if (!up_q && sp_q < cnt_q) begin
          raddr  = sp_q[AW-1:0];
          sp_d   = sp_q + CW'(1);
          pend_d = 1'b1;
          pidx_d = sp_q[AW-1:0];
        end else if (!pend_q) begin
          if (up_q) begin
            state_d = ST_PUT;
          end else begin
            cnt_d = cnt_q - CW'(1);
            fin   = 1'b1;
          end
        end
      end

      ST_PUT: begin
        we    = 1'b1;
        waddr = pick_q[AW-1:0];
        wdata = {base_q[OffsetBits-1:0], total_q[SizeBits-1:0]};
        cnt_d = cnt_q + CW'(1);
        pay_d = base_q[OffsetBits-1:0] + OffsetBits'(hdr_q);
        fin   = 1'b1;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin) begin
      state_d = ST_IDLE;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      iss_q    <= '0;
      sp_q     <= '0;
      pend_q   <= 1'b0;
      up_q     <= 1'b0;
      found_q  <= 1'b0;
      frag_q   <= '0;
      done_q   <= 1'b0;
      policy_q <= 1'b0;
      pool_q   <= PoolLimit;
      hdr_q    <= HdrBits'(12);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      iss_q   <= iss_d;
      sp_q    <= sp_d;
      pend_q  <= pend_d;
      up_q    <= up_d;
      found_q <= found_d;
      frag_q  <= frag_d;
      done_q  <= fin;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgPolicy: policy_q <= cfg_data_i[0];
          CfgPool:   pool_q   <= cfg_data_i;
          CfgHeader: hdr_q    <= cfg_data_i[HdrBits-1:0];
          default:   ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pidx_q     <= pidx_d;
    kind_q     <= kind_d;
    total_q    <= total_d;
    off_q      <= off_d;
    pend_end_q <= pend_end_d;
    base_q     <= base_d;
    psize_q    <= psize_d;
    pick_q     <= pick_d;
    stat_q     <= stat_d;
    pay_q      <= pay_d;
    frag_out_q <= frag_out_d;
  end

  assign result_valid_o   = done_q;
  assign status_o         = stat_q;
  assign payload_offset_o = pay_q;
  assign fragment_count_o = frag_out_q[FragBits-1:0];

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import bwf_pkg::*;

  localparam int unsigned MaxBlocks = 64;
  localparam int unsigned Settle    = 2 * MaxBlocks + 20;
  localparam int unsigned CycleCap  = 1000000;
  localparam longint      PoolCap   = 65536;

  typedef struct packed {
    status_t               status;
    logic [OffsetBits-1:0] offset;
    logic [FragBits-1:0]   frags;
  } outcome_t;

  typedef struct {
    kind_t               kind;
    logic [SizeBits-1:0] size;
    logic [15:0]         off;
    bit                  typed;
    outcome_t            want;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  kind_t                 kind_i;
  logic [SizeBits-1:0]   req_size_i;
  logic [OffsetBits-1:0] req_offset_i;
  logic                  result_valid_o;
  status_t               status_o;
  logic [OffsetBits-1:0] payload_offset_o;
  logic [FragBits-1:0]   fragment_count_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  cfg_idx_t              cfg_index_i;
  logic [SizeBits-1:0]   cfg_data_i;

  best_worst_fit_allocator_top #(.MAX_BLOCKS(MaxBlocks)) u_top (.*);

  // clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // allocator shadow: block table and registers
  longint   blk_base [MaxBlocks];
  longint   blk_len  [MaxBlocks];
  int       blk_num;
  bit       worst_fit;
  longint   pool_reg;
  longint   hdr_reg;
  outcome_t pending[$];
  int       fails;
  bit       calm;

  function automatic longint pool_bytes();
    return (pool_reg > PoolCap) ? PoolCap : pool_reg;
  endfunction

  function automatic longint hole_len(int h);
    longint lim;
    if (h == 0) return blk_base[0];
    lim = (h < blk_num) ? blk_base[h] : pool_bytes();
    return (lim > blk_base[h-1] + blk_len[h-1]) ? lim - (blk_base[h-1] + blk_len[h-1]) : 0;
  endfunction

  // updates the shadow table and returns the outcome of one request
  function automatic outcome_t allocator_step(kind_t k, longint size, longint off);
    outcome_t o;
    longint   need, s, base, pick_len;
    int       pick, hit;
    bit       found;
    o = '0;
    need = size + hdr_reg;
    case (k)
      KindAlloc: begin
        if (size == 0 || need > pool_bytes()) begin
          o.status = StatSize;
        end else if (blk_num >= MaxBlocks) begin
          o.status = StatNoSpace;
        end else begin
          found = (blk_num == 0);
          pick = 0;
          pick_len = 0;
          if (blk_num != 0) begin
            for (int h = 0; h <= blk_num; h++) begin
              s = hole_len(h);
              if (s >= need && (!found || (worst_fit ? s > pick_len : s < pick_len))) begin
                found = 1'b1;
                pick = h;
                pick_len = s;
              end
            end
          end
          if (!found) begin
            o.status = StatNoSpace;
          end else begin
            base = (pick == 0) ? 0 : blk_base[pick-1] + blk_len[pick-1];
            for (int i = blk_num; i > pick; i--) begin
              blk_base[i] = blk_base[i-1];
              blk_len[i]  = blk_len[i-1];
            end
            blk_base[pick] = base & 16'hFFFF;
            blk_len[pick]  = need;
            blk_num++;
            o.status = StatOk;
            o.offset = OffsetBits'(base + hdr_reg);
          end
        end
      end
      KindFree: begin
        hit = -1;
        for (int i = 0; i < blk_num; i++)
          if (hit < 0 && blk_base[i] + hdr_reg == off) hit = i;
        if (hit < 0) begin
          o.status = StatNotFound;
        end else begin
          for (int j = hit; j + 1 < blk_num; j++) begin
            blk_base[j] = blk_base[j+1];
            blk_len[j]  = blk_len[j+1];
          end
          blk_num--;
          o.status = StatOk;
        end
      end
      KindCount: begin
        s = 0;
        if (blk_num == 0) s = (pool_bytes() < need) ? 1 : 0;
        else
          for (int h = 0; h <= blk_num; h++)
            if (hole_len(h) > 0 && hole_len(h) < need) s++;
        o.status = StatOk;
        o.frags  = FragBits'(s);
      end
      default: o.status = StatSize;
    endcase
    return o;
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned n;
    n = 0;
    if (!calm)
      while ($urandom_range(99) < 24) n++;
    return n;
  endfunction

  // drive one request, returns at the edge where it is taken
  task automatic issue(kind_t k, logic [SizeBits-1:0] size, logic [15:0] off,
                       bit typed = 1'b0, outcome_t want = '0);
    int unsigned gap;
    outcome_t    got;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    kind_i       <= k;
    req_size_i   <= size;
    req_offset_i <= off;
    do @(posedge clk_i); while (busy);
    got = allocator_step(k, size, off);
    pending.push_back(typed ? want : got);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [SizeBits-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgPolicy: worst_fit = data[0];
      CfgPool:   pool_reg  = data;
      CfgHeader: hdr_reg   = data[HdrBits-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && result_valid_o) begin
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        fails++;
      end else begin
        e = pending.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          fails++;
        end
        if (payload_offset_o !== e.offset) begin
          $error("payload_offset: expected %0d, got %0d", e.offset, payload_offset_o);
          fails++;
        end
        if (fragment_count_o !== e.frags) begin
          $error("fragment_count: expected %0d, got %0d", e.frags, fragment_count_o);
          fails++;
        end
      end
    end
  end

  // run watchdog
  int unsigned cycles;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleCap) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // random request of one phase
  task automatic random_request();
    int unsigned r;
    logic [15:0] off;
    r = $urandom_range(99);
    if (r < 55) begin
      issue(KindAlloc, ($urandom_range(3) == 0) ? SizeBits'($urandom_range(2000, 1))
                                                : SizeBits'($urandom_range(80, 1)),
            16'($urandom));
    end else if (r < 83) begin
      off = 16'($urandom);
      if (blk_num > 0 && $urandom_range(9) != 0)
        off = 16'(blk_base[$urandom_range(blk_num - 1)] + hdr_reg);
      issue(KindFree, SizeBits'($urandom), off);
    end else if (r < 94) begin
      issue(KindCount, ($urandom_range(1) == 0) ? SizeBits'($urandom_range(300))
                                                : SizeBits'($urandom),
            16'($urandom));
    end else begin
      issue(kind_t'($urandom_range(3)), SizeBits'($urandom), 16'($urandom));
    end
  endtask

  row_t rows[$];

  initial begin
    logic [SizeBits-1:0] pools[5]   = '{17'd4096, 17'd1000, 17'd65536, 17'h1FFFF, 17'd300};
    logic [SizeBits-1:0] heads[5]   = '{17'd12, 17'd0, 17'd64, 17'd127, 17'd1};
    rst_ni       = 1'b0;
    start        = 1'b0;
    kind_i       = KindAlloc;
    req_size_i   = '0;
    req_offset_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CfgPolicy;
    cfg_data_i   = '0;
    calm         = 1'b0;
    blk_num      = 0;
    worst_fit    = 1'b0;
    pool_reg     = 65536;
    hdr_reg      = 12;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed table, reset settings: best fit, full pool, 12 byte header
    rows = '{
      '{KindCount, 17'd0,     16'd0,     1, '{StatOk, 16'd0, 7'd0}},
      '{KindCount, 17'd65536, 16'd0,     1, '{StatOk, 16'd0, 7'd1}},
      '{KindAlloc, 17'd0,     16'd0,     1, '{StatSize, 16'd0, 7'd0}},
      '{KindAlloc, 17'd65536, 16'd0,     1, '{StatSize, 16'd0, 7'd0}},
      '{KindAlloc, 17'h1FFFF, 16'hFFFF,  1, '{StatSize, 16'd0, 7'd0}},
      '{KindAlloc, 17'd65524, 16'd0,     1, '{StatOk, 16'd12, 7'd0}},
      '{KindAlloc, 17'd1,     16'd0,     1, '{StatNoSpace, 16'd0, 7'd0}},
      '{KindFree,  17'd0,     16'd12,    1, '{StatOk, 16'd0, 7'd0}},
      '{KindFree,  17'd0,     16'hFFFF,  1, '{StatNotFound, 16'd0, 7'd0}},
      '{2'd3,      17'h1FFFF, 16'hFFFF,  1, '{StatSize, 16'd0, 7'd0}},
      '{KindAlloc, 17'd100,   16'd0,     1, '{StatOk, 16'd12, 7'd0}},
      '{KindAlloc, 17'd200,   16'd0,     1, '{StatOk, 16'd124, 7'd0}},
      '{KindAlloc, 17'd50,    16'd0,     0, '{StatOk, 16'd0, 7'd0}},
      '{KindFree,  17'd0,     16'd124,   0, '{StatOk, 16'd0, 7'd0}},
      '{KindAlloc, 17'd10,    16'd0,     0, '{StatOk, 16'd0, 7'd0}},
      '{KindCount, 17'd300,   16'd0,     0, '{StatOk, 16'd0, 7'd0}},
      '{KindCount, 17'h1FFFF, 16'hFFFF,  0, '{StatOk, 16'd0, 7'd0}},
      '{KindFree,  17'd0,     16'd12,    0, '{StatOk, 16'd0, 7'd0}},
      '{KindAlloc, 17'd20,    16'd0,     0, '{StatOk, 16'd0, 7'd0}},
      '{KindFree,  17'd0,     16'd0,     0, '{StatOk, 16'd0, 7'd0}}
    };
    foreach (rows[i]) issue(rows[i].kind, rows[i].size, rows[i].off, rows[i].typed, rows[i].want);
    drain();

    // random phases, each under new settings; blocks survive a shrunk pool
    for (int p = 0; p < 5; p++) begin
      cfg_write(CfgPolicy, SizeBits'(p % 2));
      cfg_write(CfgPool, pools[p]);
      cfg_write(CfgHeader, heads[p]);
      if (p == 4) cfg_write(cfg_idx_t'(3), 17'h1FFFF);
      for (int n = 0; n < 180; n++) begin
        calm = (p == 2 && n >= 40 && n < 140);
        random_request();
      end
      calm = 1'b0;
      drain();
    end

    // empty pool rejects every allocate
    cfg_write(CfgPool, 17'd0);
    for (int n = 0; n < 30; n++) random_request();
    drain();

    if (fails == 0 && pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== best_worst_fit_allocator_top.f =====
rtl/bwf_pkg.sv
rtl/bwf_ram.sv
rtl/best_worst_fit_allocator_top.sv
test/tb.sv
